// ===== src/lts_pkg.sv =====
`timescale 1ns / 1ps

package lts_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int OFFSET_BITS_DEF = 32;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int UNIT_W  = 16;
  localparam int LEN_W   = 6;
  localparam int PIDX_W  = 5;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [UNIT_W-1:0] CHAR_UPPER_A = 16'h0041;
  localparam logic [UNIT_W-1:0] CHAR_UPPER_Z = 16'h005A;
  localparam logic [UNIT_W-1:0] CHAR_LOWER_A = 16'h0061;
  localparam logic [UNIT_W-1:0] CHAR_LOWER_Z = 16'h007A;
  localparam logic [UNIT_W-1:0] CHAR_DIGIT_0 = 16'h0030;
  localparam logic [UNIT_W-1:0] CHAR_DIGIT_9 = 16'h0039;
  localparam logic [UNIT_W-1:0] CHAR_USCORE  = 16'h005F;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_END  = 2'd2
  } cmd_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_CASE_SENSITIVE = 2'd1,
    REG_WHOLE_WORD     = 2'd2,
    REG_MATCH_LIMIT    = 2'd3
  } reg_idx_t;

  localparam logic KIND_HIT     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic STATUS_READY    = 1'b0;
  localparam logic STATUS_INACTIVE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        match_start;
    logic [31:0]        match_end;
    logic [COUNT_W-1:0] hit_total;
    logic               status;
    logic               last;
  } result_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
  } match_ctl_t;

  typedef struct packed {
    logic hit;          // window tail equals the pattern
    logic before_word;  // unit just before the candidate is a word unit
    logic head_word;    // first unit of the candidate is a word unit
    logic join_right;   // previous newest unit and incoming unit are both word units
  } match_info_t;

  function automatic logic [UNIT_W-1:0] fold(input logic [UNIT_W-1:0] c, input logic cs);
    logic [UNIT_W-1:0] r;
    r = c;
    if (!cs && (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]})) begin
      r = c + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    return r;
  endfunction

  function automatic logic is_word(input logic [UNIT_W-1:0] c);
    return c inside {[CHAR_DIGIT_0:CHAR_DIGIT_9], [CHAR_UPPER_A:CHAR_UPPER_Z],
                     [CHAR_LOWER_A:CHAR_LOWER_Z], CHAR_USCORE};
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
    return (x == {COUNT_W{1'b1}}) ? x : x + 1'b1;
  endfunction

  function automatic result_t make_hit(input logic [31:0] s, input logic [31:0] e,
                                       input logic [COUNT_W-1:0] cnt);
    result_t r;
    r.kind        = KIND_HIT;
    r.match_start = s;
    r.match_end   = e;
    r.hit_total   = cnt;
    r.status      = STATUS_READY;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/lts_matcher.sv =====
`timescale 1ns / 1ps

module lts_matcher import lts_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  match_ctl_t        ctl,
  input  logic [UNIT_W-1:0] unit,
  input  logic [PIDX_W-1:0] load_idx,
  input  logic [LEN_W-1:0]  len,
  input  logic              exact,
  output match_info_t       info
);

  localparam int WIN_DEPTH = PATTERN_MAX + 1;
  localparam int IDX_W = $clog2(WIN_DEPTH);
  localparam int PW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [UNIT_W-1:0] pat [PATTERN_MAX];
  logic [UNIT_W-1:0] win [WIN_DEPTH];
  logic [UNIT_W-1:0] win_new [WIN_DEPTH];
  logic [PATTERN_MAX-1:0] cmp_ok;
  logic [IDX_W-1:0] src;
  logic [IDX_W-1:0] left_idx;
  logic [IDX_W-1:0] first_idx;

  // window as it stands once the incoming unit is shifted in (newest first)
  always_comb begin
    win_new[0] = unit;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_new[k] = win[k-1];
    end
  end

  // pattern position i lines up with the unit that came len-1-i units ago
  always_comb begin
    src = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < int'(len)) begin
        src = IDX_W'(int'(len) - 1 - i);
        cmp_ok[i] = fold(pat[i], exact) == fold(win_new[src], exact);
      end else begin
        cmp_ok[i] = 1'b1;
      end
    end
  end

  assign left_idx  = IDX_W'(len);
  assign first_idx = IDX_W'(LEN_W'(len - 1'b1));

  always_comb begin
    info.hit         = &cmp_ok;
    info.before_word = is_word(win_new[left_idx]);
    info.head_word   = (len != '0) && is_word(win_new[first_idx]);
    info.join_right  = is_word(win[0]) && is_word(unit);
  end

  // pattern store: no reset, entries are defined once loaded
  always_ff @(posedge clk) begin
    if (ctl.load && (32'(load_idx) < PATTERN_MAX)) begin
      pat[PW'(load_idx)] <= unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win[k] <= '0;
      end
    end else if (ctl.shift) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

endmodule

// ===== src/lts_result_fifo.sv =====
`timescale 1ns / 1ps

module lts_result_fifo import lts_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t din0,
  input  result_t din1,
  input  logic    pop,
  output result_t dout,
  output logic    not_empty,
  output logic    room_for_two
);

  result_t mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic [FIFO_PTR_W-1:0] wr_ptr1;

  assign wr_ptr1      = wr_ptr + 1'b1;
  assign dout         = mem[rd_ptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wr_ptr] <= din0;
    end
    if (push1) begin
      mem[wr_ptr1] <= din1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push0) + FIFO_PTR_W'(push1);
      rd_ptr <= rd_ptr + FIFO_PTR_W'(pop);
      count  <= count + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1) - FIFO_CNT_W'(pop);
    end
  end

endmodule

// ===== src/literal_text_search_core.sv =====
`timescale 1ns / 1ps

// Streaming literal search over 16-bit text units.
// Input stream (s_*): tuser carries the command (load pattern unit, text unit,
// end of text); tdata carries the unit and, for loads, the pattern position.
// Output stream (m_*): one transfer per result. tuser = 0 for a hit with its
// start/end offsets and running count, 1 for the end-of-text summary; tlast
// marks the final result caused by one input transfer.
// cfg_*: register writes (pattern length, case mode, whole-word, match limit),
// taken at any edge with cfg_we high; write them only while the block is idle.
// Each input transfer is handled in the cycle it is taken; its results are
// registered into a 4-entry result queue that feeds m_*. One input transfer
// per cycle is accepted while the queue has two free slots, so throughput is
// one item per cycle as long as the receiver drains one result per cycle; an
// item that gives two results needs an extra result transfer. When the receiver
// stalls the queue fills and s_tready drops; no result is lost.
// Whole-word hits are held one text unit (or until end of text) to see the
// right neighbor. Reset empties the queue, clears the search state and sets
// the registers to their defaults; pattern entries hold garbage until loaded.

module literal_text_search_core import lts_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // unit[15:0], pattern_index[20:16], zero pad
  input  logic [1:0]           s_tuser,   // cmd[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [103:0]         m_tdata,   // match_start, match_end, hit count, status, pad
  output logic [0:0]           m_tuser,   // kind
  output logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int OW = OFFSET_BITS + 1;

  // configuration registers
  logic [LEN_W-1:0]   cfg_pattern_length;
  logic               cfg_case_sensitive;
  logic               cfg_whole_word;
  logic [COUNT_W-1:0] cfg_match_limit;

  // search state
  logic [OFFSET_BITS-1:0] text_offset, text_offset_next;
  logic [OW-1:0]          next_allowed, next_allowed_next;
  logic                   pending_hit, pending_hit_next;
  logic [OFFSET_BITS-1:0] pending_start, pending_start_next;
  logic                   pending_left, pending_left_next;
  logic [COUNT_W-1:0]     accepted_count, accepted_count_next;

  logic               s_accept;
  cmd_t               in_cmd;
  logic [UNIT_W-1:0]  in_unit;
  logic [PIDX_W-1:0]  in_pidx;
  logic [LEN_W-1:0]   eff_len;
  match_ctl_t         mctl;
  match_info_t        minfo;

  logic [OW-1:0]          t_plus;
  logic [OFFSET_BITS-1:0] cand_start;
  logic [COUNT_W-1:0]     cnt_a;
  logic [COUNT_W-1:0]     cnt_b;
  logic                   limit_hit;
  logic                   take_new;

  result_t    res0, res1, q_out;
  logic [1:0] n_res;
  logic       q_valid, q_room;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = q_room;
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_unit  = s_tdata[15:0];
  assign in_pidx  = s_tdata[20:16];

  assign eff_len = (32'(cfg_pattern_length) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                           : cfg_pattern_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_pattern_length <= '0;
      cfg_case_sensitive <= 1'b1;
      cfg_whole_word     <= 1'b0;
      cfg_match_limit    <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_PATTERN_LENGTH: cfg_pattern_length <= cfg_data[LEN_W-1:0];
        REG_CASE_SENSITIVE: cfg_case_sensitive <= cfg_data[0];
        REG_WHOLE_WORD:     cfg_whole_word     <= cfg_data[0];
        REG_MATCH_LIMIT:    cfg_match_limit    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  lts_matcher #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_matcher (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mctl),
    .unit    (in_unit),
    .load_idx(in_pidx),
    .len     (eff_len),
    .exact   (cfg_case_sensitive),
    .info    (minfo)
  );

  // candidate span ends at the incoming unit
  assign t_plus     = {1'b0, text_offset} + 1'b1;
  assign cand_start = OFFSET_BITS'(t_plus - OW'(eff_len));

  always_comb begin
    text_offset_next    = text_offset;
    next_allowed_next   = next_allowed;
    pending_hit_next    = pending_hit;
    pending_start_next  = pending_start;
    pending_left_next   = pending_left;
    accepted_count_next = accepted_count;
    mctl      = '0;
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    cnt_a     = accepted_count;
    cnt_b     = accepted_count;
    limit_hit = 1'b0;
    take_new  = 1'b0;

    if (s_accept) begin
      case (in_cmd)
        CMD_LOAD: begin
          mctl.load = 1'b1;
        end
        CMD_TEXT: begin
          mctl.shift = 1'b1;
          // settle a held whole-word hit now that its right neighbor is known
          pending_hit_next = 1'b0;
          if (pending_hit && (eff_len != '0) && !pending_left && !minfo.join_right) begin
            cnt_a = sat_inc(accepted_count);
            res0  = make_hit(32'(pending_start), 32'(pending_start) + 32'(eff_len), cnt_a);
            n_res = 2'd1;
          end
          if (text_offset != {OFFSET_BITS{1'b1}}) begin
            text_offset_next = text_offset + 1'b1;
          end
          limit_hit = (cfg_match_limit != '0) && (cnt_a >= cfg_match_limit);
          take_new  = (eff_len != '0) && !limit_hit && (t_plus >= OW'(eff_len)) &&
                      ({1'b0, cand_start} >= next_allowed) && minfo.hit;
          cnt_b = cnt_a;
          if (take_new) begin
            next_allowed_next = t_plus;
            if (cfg_whole_word) begin
              pending_hit_next   = 1'b1;
              pending_start_next = cand_start;
              pending_left_next  = (cand_start != '0) && minfo.before_word && minfo.head_word;
            end else begin
              cnt_b = sat_inc(cnt_a);
              if (n_res == 2'd0) begin
                res0 = make_hit(32'(cand_start), 32'(cand_start) + 32'(eff_len), cnt_b);
              end else begin
                res1 = make_hit(32'(cand_start), 32'(cand_start) + 32'(eff_len), cnt_b);
              end
              n_res = n_res + 2'd1;
            end
          end
          accepted_count_next = cnt_b;
        end
        CMD_END: begin
          mctl.clear = 1'b1;
          // no right neighbor at end of text
          if (pending_hit && (eff_len != '0) && !pending_left) begin
            cnt_a = sat_inc(accepted_count);
            res0  = make_hit(32'(pending_start), 32'(pending_start) + 32'(eff_len), cnt_a);
            n_res = 2'd1;
          end
          if (n_res == 2'd0) begin
            res0.kind      = KIND_SUMMARY;
            res0.hit_total = (eff_len == '0) ? '0 : cnt_a;
            res0.status    = (eff_len == '0) ? STATUS_INACTIVE : STATUS_READY;
          end else begin
            res1.kind      = KIND_SUMMARY;
            res1.hit_total = (eff_len == '0) ? '0 : cnt_a;
            res1.status    = (eff_len == '0) ? STATUS_INACTIVE : STATUS_READY;
          end
          n_res = n_res + 2'd1;
          text_offset_next    = '0;
          next_allowed_next   = '0;
          pending_hit_next    = 1'b0;
          pending_start_next  = '0;
          pending_left_next   = 1'b0;
          accepted_count_next = '0;
        end
        default: ;
      endcase
    end

    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end else if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_offset    <= '0;
      next_allowed   <= '0;
      pending_hit    <= 1'b0;
      pending_start  <= '0;
      pending_left   <= 1'b0;
      accepted_count <= '0;
    end else begin
      text_offset    <= text_offset_next;
      next_allowed   <= next_allowed_next;
      pending_hit    <= pending_hit_next;
      pending_start  <= pending_start_next;
      pending_left   <= pending_left_next;
      accepted_count <= accepted_count_next;
    end
  end

  lts_result_fifo u_results (
    .clk         (clk),
    .rst         (rst),
    .push0       (n_res != 2'd0),
    .push1       (n_res == 2'd2),
    .din0        (res0),
    .din1        (res1),
    .pop         (m_tvalid && m_tready),
    .dout        (q_out),
    .not_empty   (q_valid),
    .room_for_two(q_room)
  );

  assign m_tvalid = q_valid;
  assign m_tdata  = {7'd0, q_out.status, q_out.hit_total, q_out.match_end,
                     q_out.match_start};
  assign m_tuser  = q_out.kind;
  assign m_tlast  = q_out.last;

endmodule

// ===== tb/lts_search_checker.sv =====
`timescale 1ns / 1ps

module lts_search_checker import lts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [23:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [103:0]         m_tdata,
  input  logic [0:0]           m_tuser,
  input  logic                 m_tlast,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   awaited_count
);

  localparam int          WIN_LEN      = PATTERN_MAX_DEF + 1;
  localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS_DEF) - 64'd1;

  // predicted copy of the search state
  logic [UNIT_W-1:0]  pat_mem [PATTERN_MAX_DEF];
  logic [UNIT_W-1:0]  win [WIN_LEN];
  logic [63:0]        offset;
  logic [63:0]        next_start;
  logic               pend_valid;
  logic [63:0]        pend_start;
  logic               pend_left;
  logic [COUNT_W-1:0] hit_count;

  logic [LEN_W-1:0]   cfg_len;
  logic               cfg_cs;
  logic               cfg_ww;
  logic [31:0]        cfg_limit;

  result_t awaited_results [$];

  function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] c);
    if (!cfg_cs && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + (CHAR_LOWER_A - CHAR_UPPER_A);
    end
    return c;
  endfunction

  function automatic logic word_unit(input logic [UNIT_W-1:0] c);
    return (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
           (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
           (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) || (c == CHAR_USCORE);
  endfunction

  task automatic clear_search();
    for (int i = 0; i < WIN_LEN; i++) begin
      win[i] = '0;
    end
    offset     = '0;
    next_start = '0;
    pend_valid = 1'b0;
    pend_start = '0;
    pend_left  = 1'b0;
    hit_count  = '0;
  endtask

  task automatic record_hit(input logic [63:0] st, input int len);
    result_t r;
    if (hit_count != {COUNT_W{1'b1}}) begin
      hit_count = hit_count + 1'b1;
    end
    r.kind        = KIND_HIT;
    r.match_start = st[31:0];
    r.match_end   = st[31:0] + 32'(len);
    r.hit_total   = hit_count;
    r.status      = STATUS_READY;
    r.last        = 1'b0;
    awaited_results = {awaited_results, r};
  endtask

  task automatic search_step(input logic [1:0] cmd, input logic [UNIT_W-1:0] u,
                             input logic [PIDX_W-1:0] idx);
    int          len;
    int          n_new;
    logic [63:0] t;
    logic [63:0] st;
    logic        match;
    result_t     r;
    len = (cfg_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(cfg_len);
    n_new = 0;
    case (cmd)
      CMD_LOAD: begin
        pat_mem[idx] = u;
      end
      CMD_TEXT: begin
        // a held whole-word hit is decided by its right neighbor
        if (pend_valid) begin
          pend_valid = 1'b0;
          if (len > 0 && !(pend_left || (word_unit(win[0]) && word_unit(u)))) begin
            record_hit(pend_start, len);
            n_new++;
          end
        end
        for (int i = WIN_LEN - 1; i > 0; i--) begin
          win[i] = win[i-1];
        end
        win[0] = u;
        t = offset;
        if (offset < OFFSET_LIMIT) begin
          offset = offset + 64'd1;
        end
        if (len > 0 && !(cfg_limit != 0 && hit_count >= cfg_limit) &&
            t + 64'd1 >= 64'(len)) begin
          st = t + 64'd1 - 64'(len);
          if (st >= next_start) begin
            match = 1'b1;
            for (int i = 0; i < len; i++) begin
              if (fold_unit(pat_mem[i]) != fold_unit(win[len-1-i])) begin
                match = 1'b0;
              end
            end
            if (match) begin
              next_start = t + 64'd1;
              if (cfg_ww) begin
                pend_valid = 1'b1;
                pend_start = st;
                pend_left  = (st > 0) && word_unit(win[len]) && word_unit(win[len-1]);
              end else begin
                record_hit(st, len);
                n_new++;
              end
            end
          end
        end
        if (n_new > 0) begin
          r = awaited_results.pop_back();
          r.last = 1'b1;
          awaited_results = {awaited_results, r};
        end
      end
      CMD_END: begin
        if (pend_valid && len > 0 && !pend_left) begin
          record_hit(pend_start, len);
        end
        r.kind        = KIND_SUMMARY;
        r.match_start = '0;
        r.match_end   = '0;
        r.hit_total   = (len == 0) ? '0 : hit_count;
        r.status      = (len == 0) ? STATUS_INACTIVE : STATUS_READY;
        r.last        = 1'b1;
        awaited_results = {awaited_results, r};
        clear_search();
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t exp_r;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual kind=%0d start=%0h end=%0h count=%0h",
               $time, m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
      fail_count++;
    end else begin
      exp_r = awaited_results.pop_front();
      check_field("kind", 32'(exp_r.kind), 32'(m_tuser[0]));
      check_field("match_start", exp_r.match_start, m_tdata[31:0]);
      check_field("match_end", exp_r.match_end, m_tdata[63:32]);
      check_field("hit_total", exp_r.hit_total, m_tdata[95:64]);
      check_field("status", 32'(exp_r.status), 32'(m_tdata[96]));
      check_field("last", 32'(exp_r.last), 32'(m_tlast));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_search();
      cfg_len    = '0;
      cfg_cs     = 1'b1;
      cfg_ww     = 1'b0;
      cfg_limit  = '0;
      fail_count = 0;
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_result();
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN_LENGTH: cfg_len   = cfg_data[LEN_W-1:0];
          REG_CASE_SENSITIVE: cfg_cs    = cfg_data[0];
          REG_WHOLE_WORD:     cfg_ww    = cfg_data[0];
          REG_MATCH_LIMIT:    cfg_limit = cfg_data[31:0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready) begin
        search_step(s_tuser, s_tdata[15:0], s_tdata[20:16]);
      end
    end
    awaited_count = awaited_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lts_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         ITEM_GOAL  = 900;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;   // unit[15:0], pattern_index[20:16], zero pad
  logic [1:0]           s_tuser;   // cmd[1:0]
  logic                 m_tvalid;
  logic                 m_tready;
  logic [103:0]         m_tdata;   // match_start, match_end, hit count, status, pad
  logic [0:0]           m_tuser;   // kind
  logic                 m_tlast;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int fail_count;
  int awaited_count;
  int items_sent;
  bit no_gaps;

  logic [UNIT_W-1:0] pat [PATTERN_MAX_DEF];

  literal_text_search_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  lts_search_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .awaited_count(awaited_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_top failed");
    $finish;
  end

  // receiver: ready stretches mixed with short and long stalls
  initial begin
    int hold;
    int r;
    hold = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          m_tready <= 1'b1;
          hold = $urandom_range(1, 40);
        end else if (r < 90) begin
          m_tready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          m_tready <= 1'b0;
          hold = $urandom_range(8, 40);
        end
      end
      hold--;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [1:0] cmd, input logic [UNIT_W-1:0] u,
                           input logic [PIDX_W-1:0] idx);
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (r >= 90) begin
        gap = $urandom_range(8, 40);
      end else if (r >= 65) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {3'b000, idx, u};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // drain everything, then allow for items that produce no result
  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
  endtask

  task automatic write_all(input logic [LEN_W-1:0] len, input logic cs, input logic ww,
                           input logic [31:0] limit);
    write_reg(REG_PATTERN_LENGTH, CFG_W'(len));
    write_reg(REG_CASE_SENSITIVE, CFG_W'(cs));
    write_reg(REG_WHOLE_WORD, CFG_W'(ww));
    write_reg(REG_MATCH_LIMIT, limit);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_item(CMD_TEXT, {8'h00, s[i]}, '0);
    end
  endtask

  function automatic logic [UNIT_W-1:0] pattern_unit();
    string chars;
    chars = "abAB_1 .";
    if ($urandom_range(0, 49) == 0) begin
      return UNIT_W'($urandom_range(0, 65535));
    end
    return {8'h00, chars[$urandom_range(0, chars.len() - 1)]};
  endfunction

  // mostly pattern-like units, with ASCII range edges and full 16-bit noise
  function automatic logic [UNIT_W-1:0] filler_unit();
    string chars;
    int    r;
    chars = "abAB_1 .xZz@[`{/:9 0";
    r = $urandom_range(0, 99);
    if (r < 3) begin
      return UNIT_W'($urandom_range(0, 65535));
    end else if (r < 5) begin
      return (r == 3) ? 16'h0000 : 16'hFFFF;
    end
    return {8'h00, chars[$urandom_range(0, chars.len() - 1)]};
  endfunction

  initial begin
    int               r;
    int               eff;
    int               k;
    int               run_len;
    int               runs;
    logic [LEN_W-1:0] len;
    logic             cs;
    logic             ww;
    logic [31:0]      limit;
    logic [UNIT_W-1:0] u;
    logic [PIDX_W-1:0] idx;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_LOAD;
    cfg_we    = 1'b0;
    cfg_index = REG_PATTERN_LENGTH;
    cfg_data  = '0;
    items_sent = 0;
    no_gaps   = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern after reset: nothing found, inactive summary; unused cmd ignored
    send_item(CMD_TEXT, 16'h0000, '0);
    send_item(CMD_TEXT, 16'hFFFF, '0);
    send_item(CMD_UNUSED, 16'hFFFF, 5'h1F);
    send_item(CMD_END, '0, '0);
    settle();

    // folded compare with whole-word rule: accept, left reject, accept, right reject, accept at end
    write_all(6'd2, 1'b0, 1'b1, 32'd0);
    send_item(CMD_LOAD, 16'h0061, 5'd0);
    send_item(CMD_LOAD, 16'h0042, 5'd1);
    send_str("Ab xab ab,abc ab");
    send_item(CMD_END, '0, '0);
    settle();

    // exact compare and a limit of one
    write_all(6'd2, 1'b1, 1'b0, 32'd1);
    send_str("aBaB");
    send_item(CMD_END, '0, '0);
    settle();

    while (items_sent < ITEM_GOAL) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        len = 6'd0;
      end else if (r < 60) begin
        len = LEN_W'($urandom_range(1, 4));
      end else if (r < 80) begin
        len = LEN_W'($urandom_range(5, 8));
      end else if (r < 88) begin
        len = 6'd32;
      end else if (r < 91) begin
        len = 6'd63;
      end else if (r < 94) begin
        len = LEN_W'($urandom_range(33, 62));
      end else begin
        len = LEN_W'($urandom_range(9, 31));
      end
      cs = 1'($urandom_range(0, 1));
      ww = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 50) begin
        limit = 32'd0;
      end else if (r < 65) begin
        limit = 32'd1;
      end else if (r < 80) begin
        limit = 32'($urandom_range(2, 5));
      end else if (r < 90) begin
        limit = 32'hFFFF_FFFF;
      end else begin
        limit = $urandom;
      end
      write_all(len, cs, ww, limit);
      no_gaps = ($urandom_range(0, 9) < 3);

      eff = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(len);
      for (int i = 0; i < eff; i++) begin
        pat[i] = pattern_unit();
        send_item(CMD_LOAD, pat[i], PIDX_W'(i));
      end

      runs = $urandom_range(1, 3);
      for (int j = 0; j < runs; j++) begin
        run_len = (eff <= 8) ? $urandom_range(6, 30) : $urandom_range(20, 80);
        k = 0;
        while (k < run_len) begin
          r = $urandom_range(0, 99);
          if (eff > 0 && r < 35) begin
            // planted copy, each unit sometimes flipped in case or spoiled
            for (int i = 0; i < eff; i++) begin
              u = pat[i];
              if (((u >= CHAR_UPPER_A && u <= CHAR_UPPER_Z) ||
                   (u >= CHAR_LOWER_A && u <= CHAR_LOWER_Z)) &&
                  $urandom_range(0, 3) == 0) begin
                u = u ^ 16'h0020;
              end
              if ($urandom_range(0, 19) == 0) begin
                u = filler_unit();
              end
              send_item(CMD_TEXT, u, '0);
            end
            k += eff;
          end else if (r < 37) begin
            send_item(CMD_UNUSED, UNIT_W'($urandom_range(0, 65535)),
                      PIDX_W'($urandom_range(0, 31)));
          end else if (r < 39) begin
            idx = PIDX_W'($urandom_range(0, 31));
            pat[idx] = pattern_unit();
            send_item(CMD_LOAD, pat[idx], idx);
          end else begin
            send_item(CMD_TEXT, filler_unit(), '0);
            k++;
          end
        end
        // occasionally leave the text open so state carries into the next setting
        if ($urandom_range(0, 9) < 8) begin
          send_item(CMD_END, '0, '0);
        end
      end
      settle();
    end

    no_gaps = 1'b0;
    send_item(CMD_END, '0, '0);
    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
